/* design/rmfa_pkg.sv */
// shared constants, sideband types and codes for the resonator eigenmode block
package rmfa_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;
   localparam int LAMBDA_W  = 16;
   localparam int KIND_W    = 2;
   localparam int STATUS_W  = 3;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RADIUS    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WAVEFRONT = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ANGLE     = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_VALID    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UNSTABLE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_PINF     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MINF     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SAT      = 3'd4;

   // register indexes
   localparam logic CSR_RESULT_KIND = 1'b0;
   localparam logic CSR_WAVELENGTH  = 1'b1;
   localparam logic [LAMBDA_W-1:0] LAMBDA_RESET = 16'd1064;

   localparam logic [30:0] INV_PI_Q32 = 31'd1367130551;

   localparam int RAD_W     = 64;   // radicand width of both root chains
   localparam int ROOT_W    = 32;
   localparam int SQ_STEPS  = 32;
   localparam int DEN_W     = 33;
   localparam int QUO_W     = 49;   // quotient bits of the divider chain
   localparam int DREM_W    = 34;
   localparam int DIVIDEND_W = 63;
   localparam int LE_W      = LAMBDA_W + WORD_BITS;

   // plane depth: two front stages, root chain, divider chain,
   // two multiply stages, root chain, result stage
   localparam int PLANE_DEPTH = 2 + SQ_STEPS + QUO_W + 2 + SQ_STEPS + 1;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 unstable;
      logic [LE_W-1:0]      le;
      logic                 bneg;
      logic                 dneg;
      logic                 divz;
      logic [WORD_BITS-1:0] bmag;
      logic [DEN_W-1:0]     dmag;
   } sq1_sb_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              unstable;
      logic              divz;
      logic              neg;
      logic              bneg;
   } div_sb_type;

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic                 unstable;
      logic                 ovf;
      logic [WORD_BITS-1:0] kval;
      logic [STATUS_W-1:0]  kst;
   } sq2_sb_type;

   localparam int SQ1_SB_W = $bits(sq1_sb_type);
   localparam int DIV_SB_W = $bits(div_sb_type);
   localparam int SQ2_SB_W = $bits(sq2_sb_type);

endpackage

/* design/rmfa_sqrt_cell.sv */
// one digit cell of the pipelined integer square root chain
module rmfa_sqrt_cell
   import rmfa_pkg::*;
#(
   parameter int SB_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  x_in_bits,
   input  logic [ROOT_W+1:0] rem_prev,
   input  logic [ROOT_W-1:0] root_prev,
   input  logic [SB_W-1:0]   sb_prev,
   output logic [RAD_W-1:0]  x_next,
   output logic [ROOT_W+1:0] rem_next,
   output logic [ROOT_W-1:0] root_next,
   output logic [SB_W-1:0]   sb_next
);

   logic [RAD_W-1:0]  x_ff;
   logic [ROOT_W+1:0] rem_ff, rem_in, rem_sh, trial;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SB_W-1:0]   sb_ff;

   always_comb begin
      rem_sh = {rem_prev[ROOT_W-1:0], x_in_bits[RAD_W-1 -: 2]};
      trial  = {root_prev, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_prev[ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_prev[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= {x_in_bits[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         sb_ff   <= sb_prev;
      end
   end

   assign x_next    = x_ff;
   assign rem_next  = rem_ff;
   assign root_next = root_ff;
   assign sb_next   = sb_ff;

endmodule

/* design/rmfa_div_cell.sv */
// one quotient-bit cell of the pipelined restoring divider chain
module rmfa_div_cell
   import rmfa_pkg::*;
#(
   parameter int SB_W = 1
) (
   input  logic              clock,
   input  logic              en,
   input  logic [QUO_W-1:0]  num_prev,
   input  logic [DREM_W-1:0] rem_prev,
   input  logic [DEN_W-1:0]  den_prev,
   input  logic [SB_W-1:0]   sb_prev,
   output logic [QUO_W-1:0]  num_next,
   output logic [DREM_W-1:0] rem_next,
   output logic [DEN_W-1:0]  den_next,
   output logic [SB_W-1:0]   sb_next
);

   logic [QUO_W-1:0]  num_ff;
   logic [DREM_W-1:0] rem_ff, rem_in, rem_sh, den_x;
   logic [DEN_W-1:0]  den_ff;
   logic [SB_W-1:0]   sb_ff;
   logic              ge;

   always_comb begin
      rem_sh = {rem_prev[DREM_W-2:0], num_prev[QUO_W-1]};
      den_x  = {{(DREM_W-DEN_W){1'b0}}, den_prev};
      ge     = rem_sh >= den_x;
      rem_in = ge ? rem_sh - den_x : rem_sh;
   end

   // quotient bits shift in where the dividend bits leave
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_prev[QUO_W-2:0], ge};
         rem_ff <= rem_in;
         den_ff <= den_prev;
         sb_ff  <= sb_prev;
      end
   end

   assign num_next = num_ff;
   assign rem_next = rem_ff;
   assign den_next = den_ff;
   assign sb_next  = sb_ff;

endmodule

/* design/rmfa_plane.sv */
// eigenmode datapath of one plane: front stages, root, divider, multiply, root
module rmfa_plane
   import rmfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 en,
   input  logic [KIND_W-1:0]    kind,
   input  logic [LAMBDA_W-1:0]  lambda,
   input  logic [WORD_BITS-1:0] a,
   input  logic [WORD_BITS-1:0] b,
   input  logic [WORD_BITS-1:0] c,
   input  logic [WORD_BITS-1:0] d,
   output logic [WORD_BITS-1:0] value,
   output logic [STATUS_W-1:0]  status
);

   localparam logic [WORD_BITS-1:0] VMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] VMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   // stage 0
   logic [KIND_W-1:0]      kind0_ff;
   logic [LAMBDA_W-1:0]    lam0_ff;
   logic signed [WORD_BITS:0] s0_ff, diff0_ff, s0_in, diff0_in;
   logic [WORD_BITS-1:0]   bmag0_ff, e0_ff, bmag0_in, cmag0_in;
   logic                   bneg0_ff;

   always_comb begin
      s0_in    = $signed({a[WORD_BITS-1], a}) + $signed({d[WORD_BITS-1], d});
      diff0_in = $signed({d[WORD_BITS-1], d}) - $signed({a[WORD_BITS-1], a});
      bmag0_in = b[WORD_BITS-1] ? (~b + 1'b1) : b;
      cmag0_in = c[WORD_BITS-1] ? (~c + 1'b1) : c;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind0_ff <= kind;
         lam0_ff  <= lambda;
         s0_ff    <= s0_in;
         diff0_ff <= diff0_in;
         bmag0_ff <= bmag0_in;
         bneg0_ff <= b[WORD_BITS-1];
         e0_ff    <= (kind == KIND_RADIUS) ? bmag0_in : cmag0_in;
      end
   end

   // stage 1: stability, 4 - s^2, lambda*e, |D-A|
   localparam logic signed [WORD_BITS:0] TWO = 33'sd131072;
   logic signed [17:0] s18;
   logic signed [35:0] ss;
   logic [34:0]        p1_ff;
   sq1_sb_type         sb1_ff, sb1_in;

   always_comb begin
      s18 = s0_ff[17:0];
      ss  = s18 * s18;
      sb1_in.kind     = kind0_ff;
      sb1_in.unstable = (s0_ff <= -TWO) || (s0_ff >= TWO);
      sb1_in.le       = lam0_ff * e0_ff;
      sb1_in.bneg     = bneg0_ff;
      sb1_in.dneg     = diff0_ff[WORD_BITS];
      sb1_in.divz     = (diff0_ff == '0);
      sb1_in.bmag     = bmag0_ff;
      sb1_in.dmag     = diff0_ff[WORD_BITS] ? DEN_W'(-diff0_ff) : DEN_W'(diff0_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff  <= 35'h4_0000_0000 - 35'(ss);
         sb1_ff <= sb1_in;
      end
   end

   // first root chain: r = sqrt(p * 2^28)
   logic [RAD_W-1:0]    q1x   [0:SQ_STEPS];
   logic [ROOT_W+1:0]   q1rem [0:SQ_STEPS];
   logic [ROOT_W-1:0]   q1root[0:SQ_STEPS];
   logic [SQ1_SB_W-1:0] q1sb  [0:SQ_STEPS];

   assign q1x[0]    = {1'b0, p1_ff, 28'b0};
   assign q1rem[0]  = '0;
   assign q1root[0] = '0;
   assign q1sb[0]   = sb1_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq1
      rmfa_sqrt_cell #(.SB_W(SQ1_SB_W)) u_cell (
         .clock     (clock),
         .en        (en),
         .x_in_bits (q1x[i]),
         .rem_prev  (q1rem[i]),
         .root_prev (q1root[i]),
         .sb_prev   (q1sb[i]),
         .x_next    (q1x[i+1]),
         .rem_next  (q1rem[i+1]),
         .root_next (q1root[i+1]),
         .sb_next   (q1sb[i+1])
      );
   end

   // divider chain, shared by both uses
   sq1_sb_type        sq1_out;
   div_sb_type        dsb0;
   logic [DIVIDEND_W-1:0] dividend;
   logic [DEN_W-1:0]  den0;
   logic [QUO_W-1:0]  dnum  [0:QUO_W];
   logic [DREM_W-1:0] drem  [0:QUO_W];
   logic [DEN_W-1:0]  dden  [0:QUO_W];
   logic [DIV_SB_W-1:0] dsb [0:QUO_W];

   always_comb begin
      sq1_out = sq1_sb_type'(q1sb[SQ_STEPS]);
      if (sq1_out.kind == KIND_WAVEFRONT) begin
         dividend = {{(DIVIDEND_W-WORD_BITS-FRAC_BITS-1){1'b0}}, sq1_out.bmag,
                     {(FRAC_BITS+1){1'b0}}};
         den0     = sq1_out.dmag;
      end else begin
         dividend = {sq1_out.le, 15'b0};
         den0     = {1'b0, q1root[SQ_STEPS]};
      end
      dsb0.kind     = sq1_out.kind;
      dsb0.unstable = sq1_out.unstable;
      dsb0.divz     = sq1_out.divz;
      dsb0.neg      = sq1_out.bneg ^ sq1_out.dneg;
      dsb0.bneg     = sq1_out.bneg;
   end

   assign dnum[0] = dividend[QUO_W-1:0];
   assign drem[0] = DREM_W'(dividend[DIVIDEND_W-1:QUO_W]);
   assign dden[0] = den0;
   assign dsb[0]  = dsb0;

   for (genvar i = 0; i < QUO_W; i++) begin : g_div
      rmfa_div_cell #(.SB_W(DIV_SB_W)) u_cell (
         .clock    (clock),
         .en       (en),
         .num_prev (dnum[i]),
         .rem_prev (drem[i]),
         .den_prev (dden[i]),
         .sb_prev  (dsb[i]),
         .num_next (dnum[i+1]),
         .rem_next (drem[i+1]),
         .den_next (dden[i+1]),
         .sb_next  (dsb[i+1])
      );
   end

   // multiply stage A: partial products of q * round(2^32/pi), wavefront result
   div_sb_type       dsb_out;
   logic [QUO_W-1:0] quo;
   logic [54:0]      plo_ff;
   logic [55:0]      phi_ff;
   sq2_sb_type       sbm_ff, sbm_in;

   always_comb begin
      dsb_out = div_sb_type'(dsb[QUO_W]);
      quo     = dnum[QUO_W];
      sbm_in.kind     = dsb_out.kind;
      sbm_in.unstable = dsb_out.unstable;
      sbm_in.ovf      = 1'b0;
      if (dsb_out.divz) begin
         sbm_in.kval = dsb_out.bneg ? VMIN : VMAX;
         sbm_in.kst  = dsb_out.bneg ? ST_MINF : ST_PINF;
      end else if (!dsb_out.neg) begin
         if (quo[QUO_W-1:WORD_BITS-1] != '0) begin
            sbm_in.kval = VMAX;
            sbm_in.kst  = ST_SAT;
         end else begin
            sbm_in.kval = quo[WORD_BITS-1:0];
            sbm_in.kst  = ST_VALID;
         end
      end else begin
         if ((quo[QUO_W-1:WORD_BITS] != '0) ||
             (quo[WORD_BITS-1] && (quo[WORD_BITS-2:0] != '0))) begin
            sbm_in.kval = VMIN;
            sbm_in.kst  = ST_SAT;
         end else begin
            sbm_in.kval = ~quo[WORD_BITS-1:0] + 1'b1;
            sbm_in.kst  = ST_VALID;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         plo_ff <= quo[23:0] * INV_PI_Q32;
         phi_ff <= quo[QUO_W-1:24] * INV_PI_Q32;
         sbm_ff <= sbm_in;
      end
   end

   // multiply stage B: sum partials, anything above 64 bits overflows
   logic [79:0] prod;
   logic [RAD_W-1:0] w2_ff;
   sq2_sb_type  sbw_ff, sbw_in;

   always_comb begin
      prod       = {phi_ff, 24'b0} + {25'b0, plo_ff};
      sbw_in     = sbm_ff;
      sbw_in.ovf = (prod[79:64] != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w2_ff  <= prod[63:0];
         sbw_ff <= sbw_in;
      end
   end

   // second root chain
   logic [RAD_W-1:0]    q2x   [0:SQ_STEPS];
   logic [ROOT_W+1:0]   q2rem [0:SQ_STEPS];
   logic [ROOT_W-1:0]   q2root[0:SQ_STEPS];
   logic [SQ2_SB_W-1:0] q2sb  [0:SQ_STEPS];

   assign q2x[0]    = w2_ff;
   assign q2rem[0]  = '0;
   assign q2root[0] = '0;
   assign q2sb[0]   = sbw_ff;

   for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq2
      rmfa_sqrt_cell #(.SB_W(SQ2_SB_W)) u_cell (
         .clock     (clock),
         .en        (en),
         .x_in_bits (q2x[i]),
         .rem_prev  (q2rem[i]),
         .root_prev (q2root[i]),
         .sb_prev   (q2sb[i]),
         .x_next    (q2x[i+1]),
         .rem_next  (q2rem[i+1]),
         .root_next (q2root[i+1]),
         .sb_next   (q2sb[i+1])
      );
   end

   // result stage
   sq2_sb_type           sq2_out;
   logic [ROOT_W-1:0]    w;
   logic [WORD_BITS-1:0] value_ff, value_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   always_comb begin
      sq2_out = sq2_sb_type'(q2sb[SQ_STEPS]);
      w       = q2root[SQ_STEPS];
      unique case (sq2_out.kind)
         KIND_WAVEFRONT: begin
            value_in  = sq2_out.kval;
            status_in = sq2_out.kst;
         end
         KIND_RADIUS, KIND_ANGLE: begin
            if (sq2_out.unstable) begin
               value_in  = '0;
               status_in = ST_UNSTABLE;
            end else if (sq2_out.ovf || w[ROOT_W-1]) begin
               value_in  = VMAX;
               status_in = ST_SAT;
            end else begin
               value_in  = w;
               status_in = ST_VALID;
            end
         end
         default: begin
            value_in  = '0;
            status_in = ST_UNSTABLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign value  = value_ff;
   assign status = status_ff;

endmodule

/* design/resonator_mode_from_abcd_top.sv */
// top level: config registers, two plane pipelines, valid chain and output register
//
// Takes one pair of round-trip ABCD matrices (tangential, sagittal; signed
// Q16.16) per cycle and returns per plane the beam radius, wavefront radius
// or far-field half angle picked by result_kind, with a status code. Each
// plane is a chain of cells: a 32-cell square-root chain, a 49-cell
// restoring divider chain, two multiply stages and a second 32-cell root
// chain. One transaction is accepted every cycle while the output is drained.
// A stalled output holds the chain only once the last stage is occupied.
// Write configuration only while no transaction is in flight.
module resonator_mode_from_abcd_top
   import rmfa_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // a_t, b_t, c_t, d_t, a_s, b_s, c_s, d_s (32 bits each)
   input  logic [255:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // value_t[31:0], status_t[34:32], value_s[66:35], status_s[69:67], zero pad
   output logic [71:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic          csr_addr,
   input  logic [15:0]   csr_wdata
);

   logic [KIND_W-1:0]   kind_ff;
   logic [LAMBDA_W-1:0] lambda_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_RADIUS;
         lambda_ff <= LAMBDA_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_RESULT_KIND: kind_ff   <= csr_wdata[KIND_W-1:0];
            CSR_WAVELENGTH:  lambda_ff <= csr_wdata;
            default:         kind_ff   <= kind_ff;
         endcase
      end
   end

   logic [PLANE_DEPTH-1:0] valid_ff;
   logic                   out_valid_ff;
   logic                   en;

   // the chain stalls only when its last stage holds an item the output can't take
   assign en         = !(valid_ff[PLANE_DEPTH-1] && out_valid_ff && !rsp_tready);
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[PLANE_DEPTH-2:0], req_tvalid};
      end
   end

   logic [WORD_BITS-1:0] value_t, value_s;
   logic [STATUS_W-1:0]  status_t, status_s;

   rmfa_plane u_plane_t (
      .clock  (clock),
      .en     (en),
      .kind   (kind_ff),
      .lambda (lambda_ff),
      .a      (req_tdata[31:0]),
      .b      (req_tdata[63:32]),
      .c      (req_tdata[95:64]),
      .d      (req_tdata[127:96]),
      .value  (value_t),
      .status (status_t)
   );

   rmfa_plane u_plane_s (
      .clock  (clock),
      .en     (en),
      .kind   (kind_ff),
      .lambda (lambda_ff),
      .a      (req_tdata[159:128]),
      .b      (req_tdata[191:160]),
      .c      (req_tdata[223:192]),
      .d      (req_tdata[255:224]),
      .value  (value_s),
      .status (status_s)
   );

   logic [71:0] out_data_ff;
   logic        load;

   assign load = valid_ff[PLANE_DEPTH-1] && en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= {2'b00, status_s, value_s, status_t, value_t};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

/* dv/tb_resonator_mode_from_abcd_top.sv */
// testbench for the resonator eigenmode block: directed and randomized matrix stream with scoreboard
module tb_resonator_mode_from_abcd_top;
   import rmfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0]         value_t;
      logic [STATUS_W-1:0] status_t;
      logic [31:0]         value_s;
      logic [STATUS_W-1:0] status_s;
   } mode_result_type;

   class mode_scoreboard;
      mode_result_type     pending_modes[$];
      logic [KIND_W-1:0]   kind;
      logic [LAMBDA_W-1:0] lambda_nm;
      int                  errors;

      function new();
         kind = KIND_RADIUS;
         lambda_nm = LAMBDA_RESET;
         errors = 0;
      endfunction

      static function longint unsigned root64(longint unsigned x);
         longint unsigned r, bitv;
         r = 0;
         bitv = 64'd1 << 62;
         while (bitv > x) bitv >>= 2;
         while (bitv != 0) begin
            if (x >= r + bitv) begin
               x -= r + bitv;
               r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         return r;
      endfunction

      static function longint unsigned magn(longint v);
         return v < 0 ? 64'd0 - longint'(v) : v;
      endfunction

      // one plane: {value, status}
      function logic [34:0] eigen_plane(logic [31:0] ra, logic [31:0] rb,
                                        logic [31:0] rc, logic [31:0] rd);
         longint a, b, c, d, s, p, diff;
         longint unsigned r, e, q, w;
         logic [31:0] vmax, vmin;
         a = longint'(signed'(ra)); b = longint'(signed'(rb));
         c = longint'(signed'(rc)); d = longint'(signed'(rd));
         vmax = 32'h7fff_ffff;
         vmin = 32'h8000_0000;
         case (kind)
            KIND_WAVEFRONT: begin
               diff = d - a;
               if (diff == 0) return b < 0 ? {vmin, ST_MINF} : {vmax, ST_PINF};
               q = (magn(b) << (FRAC_BITS + 1)) / magn(diff);
               if ((b < 0) == (diff < 0)) begin
                  if (q > 64'h7fff_ffff) return {vmax, ST_SAT};
                  return {q[31:0], ST_VALID};
               end
               if (q > 64'h8000_0000) return {vmin, ST_SAT};
               return {32'd0 - q[31:0], ST_VALID};
            end
            KIND_RADIUS, KIND_ANGLE: begin
               s = a + d;
               if (s <= -(64'sd2 << FRAC_BITS) || s >= (64'sd2 << FRAC_BITS))
                  return {32'd0, ST_UNSTABLE};
               p = (64'sd4 << (2 * FRAC_BITS)) - s * s;
               r = root64(longint'(p) << 28);
               if (r == 0) r = 1;
               e = magn(kind == KIND_RADIUS ? b : c);
               q = ((longint'(lambda_nm) * e) << 15) / r;
               if (q > 64'hffff_ffff_ffff_ffff / {33'd0, INV_PI_Q32}) return {vmax, ST_SAT};
               w = root64(q * {33'd0, INV_PI_Q32});
               if (w > 64'h7fff_ffff) return {vmax, ST_SAT};
               return {w[31:0], ST_VALID};
            end
            default: return {32'd0, ST_UNSTABLE};
         endcase
      endfunction

      function void note_request(logic [255:0] data);
         mode_result_type m;
         logic [34:0] pt, ps;
         pt = eigen_plane(data[31:0], data[63:32], data[95:64], data[127:96]);
         ps = eigen_plane(data[159:128], data[191:160], data[223:192], data[255:224]);
         {m.value_t, m.status_t} = pt;
         {m.value_s, m.status_s} = ps;
         pending_modes.push_back(m);
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check_response(logic [71:0] data);
         mode_result_type m;
         if (pending_modes.size() == 0) begin
            report("unexpected transaction", data[31:0], 0);
            return;
         end
         m = pending_modes.pop_front();
         if (data[31:0] !== m.value_t) report("value_t", data[31:0], m.value_t);
         if (data[34:32] !== m.status_t) report("status_t", data[34:32], m.status_t);
         if (data[66:35] !== m.value_s) report("value_s", data[66:35], m.value_s);
         if (data[69:67] !== m.status_s) report("status_s", data[69:67], m.status_s);
      endtask
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, rsp_tvalid, rsp_tready;
   logic [255:0] req_tdata;
   logic [71:0]  rsp_tdata;
   logic         csr_we, csr_addr;
   logic [15:0]  csr_wdata;

   mode_scoreboard sb = new();
   bit  no_idle = 0;
   int  rsp_holdoff = 0;
   int  quiet_cycles = 0;

   resonator_mode_from_abcd_top dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // result side: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (rsp_holdoff > 0) begin
         rsp_tready <= 1'b0;
         rsp_holdoff--;
      end else begin
         rsp_tready <= no_idle || $urandom_range(0, 99) >= 20;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task send_matrices(logic [255:0] data);
      @(negedge clock);
      while (!no_idle && $urandom_range(0, 99) < 20) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(data);
   endtask

   task wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending_modes.size() != 0) @(negedge clock);
   endtask

   task write_csr(logic addr, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_RESULT_KIND) sb.kind = value[KIND_W-1:0];
      else sb.lambda_nm = value;
   endtask

   function logic [127:0] random_plane();
      logic [31:0] a, b, c, d, s;
      case ($urandom_range(0, 9))
         0, 1: return {$urandom, $urandom, $urandom, $urandom};
         2: begin
            a = $urandom; b = $urandom >> $urandom_range(0, 31);
            if ($urandom_range(0, 1)) b = -b;
            return {a, $urandom, b, a};   // d equals a
         end
         default: begin
            // stable round trip: |a+d| below two
            s = $urandom_range(0, 32'h3fffe) - 32'h1ffff;
            a = $urandom_range(0, 32'h3ffff) - 32'h1ffff;
            d = s - a;
            b = $urandom >> $urandom_range(1, 31);
            c = $urandom >> $urandom_range(1, 31);
            if ($urandom_range(0, 1)) b = -b;
            if ($urandom_range(0, 1)) c = -c;
            return {d, c, b, a};
         end
      endcase
   endfunction

   task send_directed();
      send_matrices('0);
      send_matrices({4{32'h0001_0000, 32'h0000_1000, 32'hffff_f000, 32'h0001_0000}});
      send_matrices({{4{32'h8000_0000}}, {4{32'h7fff_ffff}}});
      send_matrices({32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0001_ffff,
                     32'h0000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hfffe_0001});
      send_matrices({32'h0000_0001, 32'h0000_0010, 32'hffff_fff0, 32'h0000_0000,
                     32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000});
      send_matrices({32'h0000_8000, 32'h0003_0000, 32'h0002_0000, 32'hffff_8000,
                     32'h0000_4000, 32'hfffd_0000, 32'hfffc_0000, 32'h0000_c000});
      send_matrices({32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 32'h0000_0000,
                     32'h0000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h0000_0000});
   endtask

   logic [1:0]  kinds[8]   = '{KIND_RADIUS, KIND_WAVEFRONT, KIND_ANGLE, 2'd3,
                                KIND_RADIUS, KIND_ANGLE, KIND_WAVEFRONT, KIND_RADIUS};
   logic [15:0] lambdas[8] = '{16'd1064, 16'd1, 16'd65535, 16'd500,
                                16'd65535, 16'd1, 16'd633, 16'd0};

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_RESULT_KIND;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_RESULT_KIND, {14'd0, kinds[ph]});
         write_csr(CSR_WAVELENGTH, lambdas[ph]);
         no_idle = (ph == 4);
         if (ph < 4) send_directed();
         if (ph == 2) rsp_holdoff = 400;   // hold the output off long enough to stall the input
         for (int i = 0; i < 46; i++) begin
            send_matrices({random_plane(), random_plane()});
            if (ph == 5 && i == 20) wait_drained();
         end
         wait_drained();
      end
      repeat (150) @(negedge clock);
      if (sb.errors == 0 && sb.pending_modes.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end
endmodule
